[design/ptffa_pkg.sv]
// Shared types and codes for the page table with first-free frame allocation.
// No dependencies; imported by page_table_with_free_frame_alloc.
`default_nettype none

package ptffa_pkg;

    // Input operation codes
    localparam logic OP_ACCESS  = 1'b0;
    localparam logic OP_PRELOAD = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_HIT     = 3'd0,
        ST_FAULT   = 3'd1,
        ST_OOM     = 3'd2,
        ST_PRE_OK  = 3'd3,
        ST_PRE_REJ = 3'd4
    } status_t;

    // Control sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP
    } state_t;

    // Decision taken in the lookup cycle
    typedef struct packed {
        logic    load;      // move a result word into the output register
        logic    wr_page;   // write the page entry back
        logic    set_frame; // mark a frame occupied
        logic    use_free;  // the frame is the allocated one, not the requested one
        status_t status;
    } decide_t;

endpackage

`default_nettype wire

[design/page_table_with_free_frame_alloc.sv]
// Page table with first-free frame allocation: top level.
// Depends on ptffa_pkg (status codes, sequencer states, decision struct).
//
// Each input word either accesses a page (hit returns its frame; a miss maps the page into
// the lowest free frame and reports a fault, or reports out of memory when all frames are
// taken or the page is out of range) or preloads a page into a named frame (done only if the
// frame is free and the page unmapped, otherwise rejected). Each word gives exactly one
// result word. S_IDLE reads the page entry from the synchronous page memory on accept;
// S_LOOKUP decides and writes the entry back, waiting while the output register is full;
// no word is accepted until the lookup ends. The result register holds a finished word
// while the next item is accepted. After reset the page memory is cleared by a sweep, one
// entry per cycle, during which no input word is accepted. Frame occupancy sits in a
// flip-flop bitmap scanned by a priority encoder whose result is registered at accept time.
`default_nettype none

module page_table_with_free_frame_alloc
    import ptffa_pkg::*;
#(
    parameter int PAGE_COUNT  = 32,
    parameter int FRAME_COUNT = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_operation,
    input  wire logic [4:0] s_page,
    input  wire logic [3:0] s_frame,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_status,
    output logic [3:0]      m_frame_out
);

    localparam int PAGE_IDX_W  = $clog2(PAGE_COUNT);
    localparam int FRAME_IDX_W = $clog2(FRAME_COUNT);
    localparam int ENTRY_W     = FRAME_IDX_W + 1;   // valid bit on top of the frame number
    localparam logic [PAGE_IDX_W-1:0] LAST_PAGE = PAGE_IDX_W'(PAGE_COUNT - 1);

    // ------------------------------------------------------------------
    // Sequencer state and control registers
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [PAGE_IDX_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [FRAME_COUNT-1:0]  occupied_reg, occupied_next;
    logic                    m_valid_reg, m_valid_next;

    // Payload of the item in flight (captured on accept, no reset needed)
    logic                    op_reg;
    logic                    page_ok_reg;
    logic                    frame_ok_reg;
    logic [PAGE_IDX_W-1:0]   page_idx_reg;
    logic [FRAME_IDX_W-1:0]  frame_idx_reg;
    logic                    free_found_reg;
    logic [FRAME_IDX_W-1:0]  free_idx_reg;

    // Output word
    logic [2:0]              m_status_reg;
    logic [3:0]              m_frame_out_reg;

    // Page memory and its ports
    logic [ENTRY_W-1:0]      page_mem [PAGE_COUNT];
    logic [ENTRY_W-1:0]      rd_data_reg;
    logic                    mem_re;
    logic                    mem_we;
    logic [PAGE_IDX_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0]      mem_wdata;

    // Address and range decode of the incoming word
    logic [PAGE_IDX_W+4:0]   page_wide;
    logic [FRAME_IDX_W+3:0]  frame_wide;
    logic [PAGE_IDX_W-1:0]   in_page_idx;
    logic [FRAME_IDX_W-1:0]  in_frame_idx;
    logic                    in_page_ok;
    logic                    in_frame_ok;

    // First-free search
    logic                    free_found;
    logic [FRAME_IDX_W-1:0]  free_idx;

    // Lookup-cycle decode
    logic                    accept;
    logic                    out_free;
    logic                    clr_done;
    logic                    entry_valid;
    logic [FRAME_IDX_W-1:0]  entry_frame;
    logic [FRAME_IDX_W-1:0]  res_frame;
    logic [FRAME_IDX_W+3:0]  res_frame_wide;
    decide_t                 dec;

    assign page_wide    = {{PAGE_IDX_W{1'b0}}, s_page};
    assign frame_wide   = {{FRAME_IDX_W{1'b0}}, s_frame};
    assign in_page_idx  = page_wide[PAGE_IDX_W-1:0];
    assign in_frame_idx = frame_wide[FRAME_IDX_W-1:0];
    assign in_page_ok   = 32'(s_page) < PAGE_COUNT;
    assign in_frame_ok  = 32'(s_frame) < FRAME_COUNT;

    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign clr_done    = clr_cnt_reg == LAST_PAGE;
    assign entry_valid = rd_data_reg[FRAME_IDX_W];
    assign entry_frame = rd_data_reg[FRAME_IDX_W-1:0];

    // Lowest free frame; scan from the top so the lowest index wins
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int k = FRAME_COUNT - 1; k >= 0; k--) begin
            if (!occupied_reg[k]) begin
                free_found = 1'b1;
                free_idx   = FRAME_IDX_W'(k);
            end
        end
    end

    // ------------------------------------------------------------------
    // Lookup decision: page entry read data is valid in S_LOOKUP
    // ------------------------------------------------------------------
    always_comb begin
        dec        = '0;
        dec.status = ST_OOM;
        if (state_reg == S_LOOKUP && out_free) begin
            dec.load = 1'b1;
            if (op_reg == OP_PRELOAD) begin
                // frame_ok guards the bitmap index
                if (page_ok_reg && frame_ok_reg && !entry_valid &&
                    !occupied_reg[frame_idx_reg]) begin
                    dec.status    = ST_PRE_OK;
                    dec.wr_page   = 1'b1;
                    dec.set_frame = 1'b1;
                end else begin
                    dec.status = ST_PRE_REJ;
                end
            end else if (!page_ok_reg) begin
                dec.status = ST_OOM;
            end else if (entry_valid) begin
                dec.status = ST_HIT;
            end else if (free_found_reg) begin
                dec.status    = ST_FAULT;
                dec.wr_page   = 1'b1;
                dec.set_frame = 1'b1;
                dec.use_free  = 1'b1;
            end else begin
                dec.status = ST_OOM;
            end
        end
    end

    always_comb begin
        case (dec.status)
            ST_HIT:    res_frame = entry_frame;
            ST_FAULT:  res_frame = free_idx_reg;
            ST_PRE_OK: res_frame = frame_idx_reg;
            default:   res_frame = '0;
        endcase
    end
    // Frame number masked to the 4-bit result field
    assign res_frame_wide = {4'b0000, res_frame};

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (clr_done) state_next = S_IDLE;
            S_IDLE:   if (s_valid) state_next = S_LOOKUP;
            S_LOOKUP: if (out_free) state_next = S_IDLE;
            default:  state_next = S_CLEAR;
        endcase
    end

    // Sequencer: outputs and memory controls
    always_comb begin
        s_ready      = 1'b0;
        mem_re       = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = page_idx_reg;
        mem_wdata    = '0;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            S_CLEAR: begin
                // Sweep every entry to invalid, frame zero
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
            S_IDLE: begin
                s_ready = 1'b1;
                mem_re  = s_valid;
            end
            S_LOOKUP: begin
                mem_we    = dec.wr_page;
                mem_wdata = {1'b1, dec.use_free ? free_idx_reg : frame_idx_reg};
            end
            default: ;
        endcase
    end

    // Occupancy bitmap and output valid
    always_comb begin
        occupied_next = occupied_reg;
        if (dec.set_frame) begin
            occupied_next[dec.use_free ? free_idx_reg : frame_idx_reg] = 1'b1;
        end
        if (dec.load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            occupied_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            occupied_reg <= occupied_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Capture the item and the free-frame search on accept
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg         <= s_operation;
            page_ok_reg    <= in_page_ok;
            frame_ok_reg   <= in_frame_ok;
            page_idx_reg   <= in_page_idx;
            frame_idx_reg  <= in_frame_idx;
            free_found_reg <= free_found;
            free_idx_reg   <= free_idx;
        end
        if (dec.load) begin
            m_status_reg    <= dec.status;
            m_frame_out_reg <= res_frame_wide[3:0];
        end
    end

    // Page memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            page_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= page_mem[in_page_idx];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_frame_out = m_frame_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_ready)
        else $error("input accepted during page memory clear");

    a_result_from_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_LOOKUP))
        else $error("result word without a lookup");

    a_alloc_marks_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        dec.set_frame |=> occupied_reg[$past(dec.use_free ? free_idx_reg : frame_idx_reg)])
        else $error("mapped frame not marked occupied");

    a_fault_needs_free: assert property (@(posedge aclk) disable iff (!aresetn)
        dec.status == ST_FAULT && dec.load |-> !occupied_reg[free_idx_reg])
        else $error("fault allocated an occupied frame");

    a_zero_frame_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg == ST_OOM || m_status_reg == ST_PRE_REJ)
            |-> m_frame_out_reg == 4'd0)
        else $error("failed result carries a nonzero frame");

endmodule

`default_nettype wire
